>>> src/brfp_pkg.sv
package brfp_pkg;

	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

	localparam int MODE_W = 3;
	localparam int BYTE_W = 8;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_GET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

>>> src/byte_ring_fifo_with_peek_top.sv
// byte fifo on a power-of-two ring, one slot kept empty (holds DEPTH-1 bytes)
// input channel s_axis: one transfer is one operation; tuser carries the mode
// (put, get, peek, skip, flush, contiguous query), tdata the byte and arguments
// output channel m_axis: exactly one result transfer per input transfer, in order
// the result is worked out in the calc step and written into the output register in
// the write-back step, which waits until the output register is free
// a new operation is taken only after the last one has gone through the
// read-then-commit sequence around the single ring ram read port
// the input is taken again while a finished result still waits in the output
// register; if the receiver stalls, the next operation waits in its last step
// and s_axis_tready stays low until the output register frees up
// reset clears head, tail, the controller state and the output valid flag;
// ring contents stay undefined and are never read before being written
module byte_ring_fifo_with_peek_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_in, offset, length
	input  logic [2:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // ok, data_out, count, fill_level, free_space,
	                                   // is_empty, is_full, zero pad
);

	brfp_pkg::cmd_t  cmd;
	brfp_pkg::stat_t stat;

	brfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	brfp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_mode  (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an operation is in flight");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared one cycle after input transfer");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[33] && m_axis_tdata[34]))
		else $error("ring reported empty and full at once");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("failed operation returned data");

endmodule

>>> src/brfp_ram.sv
module brfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/brfp_ctrl.sv
module brfp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  brfp_pkg::stat_t stat,
	output brfp_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/brfp_dp.sv
module brfp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  brfp_pkg::cmd_t                     cmd,
	output brfp_pkg::stat_t                    stat,
	input  logic [brfp_pkg::MODE_W-1:0]        in_mode,
	input  logic [brfp_pkg::IN_TDATA_W-1:0]    in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [brfp_pkg::OUT_TDATA_W-1:0]   out_data
);

	localparam int IW = brfp_pkg::IDX_W;
	localparam int CW = brfp_pkg::CW;
	localparam int BW = brfp_pkg::BYTE_W;

	function automatic logic [BW-1:0] sat8(input logic [CW-1:0] v);
		sat8 = (v > CW'(255)) ? BW'(255) : v[BW-1:0];
	endfunction

	logic [brfp_pkg::MODE_W-1:0] mode_q;
	logic [BW-1:0] din_q, off_q, len_q;
	logic [IW-1:0] head_q, tail_q, head_nx_q, tail_nx_q;
	logic          ok_q;
	logic [BW-1:0] cnt_q;

	logic [IW-1:0] avail, raddr, start;
	logic [CW-1:0] avail_w, off_w, len_w, clamp_w, run_w, rest_w, qcnt_w;
	logic          off_in;
	logic          ok_d;
	logic [BW-1:0] cnt_d;
	logic [IW-1:0] head_d, tail_d;
	logic [BW-1:0] rdata;
	logic          ram_we;

	logic [IW-1:0] fill_nx;
	logic [CW-1:0] free_w;
	logic          empty_nx, full_nx;
	logic [BW-1:0] dout;

	assign avail   = tail_q - head_q;
	assign avail_w = CW'(avail);
	assign off_w   = CW'(off_q);
	assign len_w   = CW'(len_q);
	assign off_in  = off_w < avail_w;
	assign start   = head_q + IW'(off_q);
	assign raddr   = (mode_q == brfp_pkg::MODE_PEEK) ? start : head_q;
	assign clamp_w = (len_w > avail_w) ? avail_w : len_w;
	assign run_w   = CW'(brfp_pkg::DEPTH) - CW'(start);
	assign rest_w  = avail_w - off_w;
	assign qcnt_w  = (run_w < rest_w) ? run_w : rest_w;

	always_comb begin
		ok_d = 1'b0;
		cnt_d = '0;
		head_d = head_q;
		tail_d = tail_q;
		case (mode_q)
			brfp_pkg::MODE_PUT: begin
				if (tail_q + IW'(1) != head_q) begin
					ok_d = 1'b1;
					tail_d = tail_q + IW'(1);
				end
			end
			brfp_pkg::MODE_GET: begin
				if (avail != '0) begin
					ok_d = 1'b1;
					head_d = head_q + IW'(1);
				end
			end
			brfp_pkg::MODE_PEEK: begin
				ok_d = off_in;
			end
			brfp_pkg::MODE_SKIP: begin
				ok_d = 1'b1;
				cnt_d = sat8(clamp_w);
				head_d = head_q + IW'(clamp_w);
			end
			brfp_pkg::MODE_FLUSH: begin
				ok_d = 1'b1;
				head_d = tail_q;
			end
			brfp_pkg::MODE_QUERY: begin
				if (off_in) begin
					ok_d = 1'b1;
					cnt_d = sat8(qcnt_w);
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			din_q  <= in_data[7:0];
			off_q  <= in_data[15:8];
			len_q  <= in_data[23:16];
		end
		if (cmd.calc) begin
			ok_q      <= ok_d;
			cnt_q     <= cnt_d;
			head_nx_q <= head_d;
			tail_nx_q <= tail_d;
		end
	end

	assign ram_we = cmd.commit && ok_q && (mode_q == brfp_pkg::MODE_PUT);

	brfp_ram #(
		.WIDTH(BW),
		.DEPTH(brfp_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(din_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign fill_nx  = tail_nx_q - head_nx_q;
	assign free_w   = CW'(brfp_pkg::DEPTH - 1) - CW'(fill_nx);
	assign empty_nx = head_nx_q == tail_nx_q;
	assign full_nx  = (tail_nx_q + IW'(1)) == head_nx_q;
	assign dout     = (ok_q && (mode_q == brfp_pkg::MODE_GET ||
		mode_q == brfp_pkg::MODE_PEEK)) ? rdata : '0;

	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.commit) begin
				head_q    <= head_nx_q;
				tail_q    <= tail_nx_q;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data <= {5'b0, full_nx, empty_nx, sat8(free_w), sat8(CW'(fill_nx)),
				cnt_q, dout, ok_q};
		end
	end

endmodule
